[rtl/core/page_frame_bitmap_allocator_assert.svh]
// Assertion macros for the page frame allocator.
// Define NO_ASSERTIONS to compile them out.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PFBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfba: implication check failed");
`define PFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfba: next-cycle check failed");
`else
`define PFBA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/pfba_pkg.sv]
`default_nettype none

package pfba_pkg;

    localparam int ADDR_W          = 32;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam int FCOUNT_W        = 16;
    localparam int FRAME_SHIFT     = 12;
    localparam int PAGE_IDX_W      = ADDR_W - FRAME_SHIFT;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam int MAX_FRAMES_DEF    = 32768;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 16'd32768;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

endpackage

`default_nettype wire

[rtl/core/pfba_if.sv]
`default_nettype none

interface pfba_req_if import pfba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [ADDR_W-1:0]   address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface pfba_rsp_if import pfba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   frame_address;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output frame_address, output status, input ready);
    modport sink   (input valid, input frame_address, input status, output ready);
endinterface

interface pfba_cfg_if import pfba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/page_frame_bitmap_allocator.sv]
// First-fit page frame allocator over a used-bit map, 4 KiB frames.
// Channels: i_req takes one request word (opcode, address), o_rsp returns one
// word (frame_address, status) per request, i_cfg writes base_address (index 0)
// or frame_count (index 1) and is always ready; write it only while idle.
// One request is in flight at a time; i_req.ready is high only when idle, and
// the next request can be taken once the current word has entered o_rsp.
// Path from accept to o_rsp.valid:
//   range error, count of zero or unused opcode: straight to S_PUSH
//   allocate: map words are read from word 0 up to the one holding the first
//     free frame (one map word read per cycle, pipelined against the bit
//     search); a full map reads every word up to the frame count
//   free / mark: the reciprocal frame-to-word divider, then the
//     read-modify-write of one map word
// After reset the map RAM is swept to zero, one word per cycle, over all
// ceil(MAX_FRAMES / MAP_WORD_BITS) words (1024 at defaults); no request is
// taken during the sweep, config writes are. A stalled o_rsp holds its word
// in the output register; the next request is still taken and its word
// waits until the register drains.
`default_nettype none
`include "page_frame_bitmap_allocator_assert.svh"

module page_frame_bitmap_allocator import pfba_pkg::*; #(
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pfba_req_if.sink    i_req,
    pfba_rsp_if.source  o_rsp,
    pfba_cfg_if.sink    i_cfg
);

    localparam int WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int WB_W  = $clog2(MAX_FRAMES + MAP_WORD_BITS + 1);
    localparam int BS_W  = $clog2(MAP_WORD_BITS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_WR,
        S_PUSH
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]   r_base;
    logic [FCOUNT_W-1:0] r_frame_count;
    logic [WA_W-1:0]     r_clr, n_clr;
    logic [OP_W-1:0]     r_op, n_op;

    // scan pipeline: read side and check side
    logic [WA_W:0]       r_rd_word, n_rd_word;
    logic [WB_W-1:0]     r_rd_wbase, n_rd_wbase;
    logic                r_rd_done, n_rd_done;
    logic                r_chk_vld, n_chk_vld;
    logic [WA_W-1:0]     r_chk_word, n_chk_word;
    logic [WB_W-1:0]     r_chk_wbase, n_chk_wbase;
    logic                r_chk_last, n_chk_last;

    logic [WA_W-1:0]     r_word, n_word;
    logic [BS_W-1:0]     r_bit, n_bit;

    logic                r_res_ok, n_res_ok;
    logic [WB_W-1:0]     r_res_idx, n_res_idx;
    logic [STATUS_W-1:0] r_res_status, n_res_status;

    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic [CNT_W-1:0]    active_n;
    logic [WB_W-1:0]     n_ext;
    logic [ADDR_W-1:0]   offset;
    logic [PAGE_IDX_W-1:0] page_idx;
    logic                range_err;

    logic                     ram_we;
    logic [WA_W-1:0]          ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic                     ram_re;
    logic [WA_W-1:0]          ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    logic                div_start;
    logic                div_done;
    logic [IDX_W-1:0]    div_quot;
    logic [BS_W-1:0]     div_rem;

    logic                found;
    logic [BS_W-1:0]     found_bit;
    logic [WB_W-1:0]     remaining;
    logic                rd_last;

    pfba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pfba_div #(
        .IN_W    (IDX_W),
        .DIVISOR (MAP_WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (page_idx[IDX_W-1:0]),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign i_cfg.ready         = 1'b1;
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.frame_address = r_out_addr;
    assign o_rsp.status        = r_out_status;

    // active count saturates at MAX_FRAMES
    always_comb begin
        if (32'(r_frame_count) > 32'(MAX_FRAMES)) begin
            active_n = CNT_W'(MAX_FRAMES);
        end else begin
            active_n = CNT_W'(r_frame_count);
        end
        n_ext     = WB_W'(active_n);
        offset    = i_req.address - r_base;
        page_idx  = offset[ADDR_W-1:FRAME_SHIFT];
        range_err = (i_req.address < r_base) || (32'(page_idx) >= 32'(active_n));
    end

    // lowest free bit of the checked word, frames at or past the count masked
    always_comb begin
        remaining = n_ext - r_chk_wbase;
        found     = 1'b0;
        found_bit = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if ((remaining > WB_W'(b)) && !ram_rdata[b]) begin
                found     = 1'b1;
                found_bit = BS_W'(b);
            end
        end
        rd_last = ((r_rd_wbase + WB_W'(MAP_WORD_BITS)) >= n_ext);
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_op         = r_op;
        n_rd_word    = r_rd_word;
        n_rd_wbase   = r_rd_wbase;
        n_rd_done    = r_rd_done;
        n_chk_vld    = 1'b0;
        n_chk_word   = r_chk_word;
        n_chk_wbase  = r_chk_wbase;
        n_chk_last   = r_chk_last;
        n_word       = r_word;
        n_bit        = r_bit;
        n_res_ok     = r_res_ok;
        n_res_idx    = r_res_idx;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        div_start    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == WA_W'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op         = i_req.opcode;
                    n_res_ok     = 1'b0;
                    n_res_status = ST_OK;
                    n_state      = S_PUSH;
                    case (i_req.opcode) inside
                        OP_ALLOC: begin
                            if (active_n == '0) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_rd_word  = '0;
                                n_rd_wbase = '0;
                                n_rd_done  = 1'b0;
                                n_state    = S_SCAN;
                            end
                        end
                        OP_FREE, OP_MARK: begin
                            if (range_err) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_rd_done) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_rd_word[WA_W-1:0];
                    n_rd_word   = r_rd_word + 1'b1;
                    n_rd_wbase  = r_rd_wbase + WB_W'(MAP_WORD_BITS);
                    n_rd_done   = rd_last;
                    n_chk_vld   = 1'b1;
                    n_chk_word  = r_rd_word[WA_W-1:0];
                    n_chk_wbase = r_rd_wbase;
                    n_chk_last  = rd_last;
                end
                if (r_chk_vld) begin
                    if (found) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_chk_word;
                        ram_wdata    = ram_rdata | (MAP_WORD_BITS'(1) << found_bit);
                        n_res_ok     = 1'b1;
                        n_res_idx    = r_chk_wbase + WB_W'(found_bit);
                        n_res_status = ST_OK;
                        n_state      = S_PUSH;
                    end else if (r_chk_last) begin
                        n_res_status = ST_FULL;
                        n_state      = S_PUSH;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    ram_re    = 1'b1;
                    ram_raddr = WA_W'(div_quot);
                    n_word    = WA_W'(div_quot);
                    n_bit     = div_rem;
                    n_state   = S_WR;
                end
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_word;
                if (r_op == OP_MARK) begin
                    ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << r_bit);
                end else begin
                    ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << r_bit);
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_ok
                        ? r_base + (ADDR_W'(r_res_idx) << FRAME_SHIFT) : '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_rd_word    <= n_rd_word;
        r_rd_wbase   <= n_rd_wbase;
        r_chk_word   <= n_chk_word;
        r_chk_wbase  <= n_chk_wbase;
        r_chk_last   <= n_chk_last;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_res_ok     <= n_res_ok;
        r_res_idx    <= n_res_idx;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_rd_done     <= 1'b1;
            r_chk_vld     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_base        <= '0;
            r_frame_count <= FRAME_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rd_done   <= n_rd_done;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_BASE:  r_base        <= i_cfg.data;
                    CFG_COUNT: r_frame_count <= i_cfg.data[FCOUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    `PFBA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `PFBA_ASSERT_IMPL(a_no_rsp_in_sweep, i_clk, i_rst_n, r_state == S_CLEAR, !o_rsp.valid)
    `PFBA_ASSERT_IMPL(a_fail_addr_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_OK), o_rsp.frame_address == '0)
    `PFBA_ASSERT_IMPL(a_write_states, i_clk, i_rst_n, ram_we, r_state == S_CLEAR || r_state == S_SCAN || r_state == S_WR)
    `PFBA_ASSERT_IMPL(a_div_done_state, i_clk, i_rst_n, div_done, r_state == S_DIV)

endmodule

`default_nettype wire

[rtl/core/pfba_ram.sv]
`default_nettype none

module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/pfba_div.sv]
`default_nettype none

// Divide by a constant via a reciprocal multiply; o_done rises with quot and rem.
// The reciprocal is rounded up with IN_W + log2(DIVISOR) fraction bits, which
// keeps the quotient exact for every IN_W-bit dividend.
module pfba_div #(
    parameter int IN_W    = 15,
    parameter int DIVISOR = 32,
    localparam int R_W    = $clog2(DIVISOR),
    localparam int SH     = IN_W + R_W,
    localparam int M_W    = IN_W + 2,
    localparam int P_W    = IN_W + M_W
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [IN_W-1:0] i_dividend,
    output logic                 o_done,
    output logic      [IN_W-1:0] o_quot,
    output logic      [R_W-1:0]  o_rem
);

    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

    logic [IN_W-1:0] r_x;
    logic [P_W-1:0]  r_prod;
    logic            r_busy;
    logic            r_done;
    logic [IN_W-1:0] r_q;
    logic [R_W-1:0]  r_rem;
    logic [IN_W-1:0] quot;
    logic [IN_W-1:0] back;

    always_comb begin
        quot = IN_W'(r_prod >> SH);
        back = quot * DIV_C;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_dividend;
            r_prod <= P_W'(i_dividend) * P_W'(RECIP);
        end
        if (r_busy) begin
            r_q   <= quot;
            r_rem <= R_W'(r_x - back);
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import pfba_pkg::*;

    localparam logic [OP_W-1:0]      OP_NONE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int IDLE_LIMIT   = 20000;
    localparam int MAX_GAP      = 17;
    localparam int PAGE_BYTES   = 1 << FRAME_SHIFT;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 210;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_address;
        logic [STATUS_W-1:0] status;
    } alloc_reply_t;

    logic i_clk;
    logic i_rst_n;

    pfba_req_if req_bus ();
    pfba_rsp_if rsp_bus ();
    pfba_cfg_if cfg_bus ();

    page_frame_bitmap_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    // shadow of the used-frame map and the two registers
    bit                  frame_used [MAX_FRAMES_DEF];
    logic [ADDR_W-1:0]   base_addr_q;
    logic [FCOUNT_W-1:0] frame_count_q;
    alloc_reply_t        pending_replies [$];
    int                  mismatch_count;
    int                  idle_cycles;
    bit                  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned active_frames();
        return (frame_count_q > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frame_count_q;
    endfunction

    function automatic alloc_reply_t apply_request(input logic [OP_W-1:0] op,
                                                   input logic [ADDR_W-1:0] addr);
        alloc_reply_t      reply;
        int unsigned       n;
        logic [ADDR_W-1:0] page;
        reply.frame_address = '0;
        reply.status        = ST_OK;
        n = active_frames();
        case (op)
            OP_ALLOC: begin
                reply.status = ST_FULL;
                for (int unsigned i = 0; i < n; i++) begin
                    if (!frame_used[i]) begin
                        frame_used[i]       = 1'b1;
                        reply.frame_address = base_addr_q + (ADDR_W'(i) << FRAME_SHIFT);
                        reply.status        = ST_OK;
                        break;
                    end
                end
            end
            OP_FREE, OP_MARK: begin
                page = (addr - base_addr_q) >> FRAME_SHIFT;
                if (addr < base_addr_q || page >= n) begin
                    reply.status = ST_RANGE;
                end else begin
                    frame_used[page] = (op == OP_MARK);
                end
            end
            default: ;
        endcase
        return reply;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.opcode  <= op;
        req_bus.address <= addr;
        do @(posedge i_clk); while (!req_bus.ready);
        pending_replies.push_back(apply_request(op, addr));
    endtask

    task automatic park_request();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
    endtask

    // registers only change with nothing in flight
    task automatic drain_replies();
        park_request();
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_BASE:  base_addr_q   = data;
            CFG_COUNT: frame_count_q = data[FCOUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_allocate_after_reset();
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 32'h0000_1123);   // unaligned, frame 1
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_NONE, 32'hFFFF_FFFF);
    endtask

    task automatic test_range_checks();
        send_request(OP_MARK, 32'hFFFF_FFFF);
        send_request(OP_MARK, 32'h07FF_FFFF);   // top frame
        send_request(OP_MARK, 32'h07FF_F000);
        send_request(OP_FREE, 32'h07FF_F800);
        send_request(OP_FREE, 32'h0800_0000);   // first index past the count
    endtask

    task automatic test_wrap_below_base();
        drain_replies();
        write_register(CFG_BASE, 32'hFFFF_E000);
        write_register(CFG_COUNT, 32'd4);
        send_request(OP_ALLOC, '0);             // frame 3 wraps past 2^32
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 32'h0000_0FFF);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, '0);
    endtask

    task automatic test_zero_count();
        drain_replies();
        write_register(CFG_BASE, '0);
        write_register(CFG_COUNT, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_MARK, '0);
    endtask

    task automatic test_count_saturation();
        drain_replies();
        write_register(CFG_COUNT, 32'hABCD_FFFF);
        write_register(CFG_BASE, 32'hFFFF_FFFF);
        write_register(CFG_SPARE_2, 32'h5555_AAAA);
        write_register(CFG_SPARE_3, 32'hAAAA_5555);
        send_request(OP_MARK, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FFFE);
        drain_replies();
        write_register(CFG_BASE, '0);
        send_request(OP_MARK, 32'h07FF_F000);
        send_request(OP_MARK, 32'h0800_0000);
        send_request(OP_ALLOC, '0);
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0]     base;
        logic [CFG_DATA_W-1:0] count_word;
        logic [OP_W-1:0]       op;
        logic [ADDR_W-1:0]     addr;
        int unsigned           n;
        int                    pick;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_replies();
            case ($urandom_range(0, 4))
                0:       base = '0;
                1:       base = 32'hFFFF_FFFF;
                2:       base = $urandom() & 32'hFFFF_F000;
                default: base = $urandom();
            endcase
            count_word = $urandom();
            // mostly small windows so allocations hit the full case quickly
            case ($urandom_range(0, 9))
                0:       count_word[15:0] = '0;
                1:       count_word[15:0] = 16'd32768;
                2:       count_word[15:0] = 16'($urandom_range(32769, 65535));
                3, 4:    count_word[15:0] = 16'($urandom_range(1, 1000));
                default: count_word[15:0] = 16'($urandom_range(1, 64));
            endcase
            write_register(CFG_BASE, base);
            write_register(CFG_COUNT, count_word);
            no_idle = (phase % 4 == 3);
            n = active_frames();
            for (int item = 0; item < PHASE_ITEMS; item++) begin
                pick = $urandom_range(0, 99);
                addr = $urandom();
                if (pick < 40) begin
                    op = OP_ALLOC;
                end else if (pick < 92) begin
                    op = pick[0] ? OP_FREE : OP_MARK;
                    if (pick < 85 && n > 0) begin
                        addr = base + (ADDR_W'($urandom_range(0, n - 1)) << FRAME_SHIFT)
                             + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
                    end else if (pick < 87) begin
                        addr = base - ADDR_W'($urandom_range(1, PAGE_BYTES));
                    end else if (pick < 89) begin
                        addr = base + (ADDR_W'(n) << FRAME_SHIFT);
                    end
                end else begin
                    op = OP_NONE;
                end
                send_request(op, addr);
            end
        end
        no_idle = 1'b0;
    endtask

    // response side back-pressure
    initial begin
        int hold;
        rsp_bus.ready = 1'b0;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            repeat (hold) begin
                @(negedge i_clk);
                rsp_bus.ready <= 1'b0;
            end
            @(negedge i_clk);
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_bus.valid && rsp_bus.ready));
        end
    end

    always @(posedge i_clk) begin
        alloc_reply_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected word: frame_address %h status %0d",
                       rsp_bus.frame_address, rsp_bus.status);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (rsp_bus.frame_address !== want.frame_address) begin
                    $error("frame_address: expected %h, actual %h",
                           want.frame_address, rsp_bus.frame_address);
                    mismatch_count++;
                end
                if (rsp_bus.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.opcode  = OP_ALLOC;
        req_bus.address = '0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = CFG_BASE;
        cfg_bus.data    = '0;
        base_addr_q     = '0;
        frame_count_q   = FRAME_COUNT_RST;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_allocate_after_reset();
        test_range_checks();
        test_wrap_below_base();
        test_zero_count();
        test_count_saturation();
        test_random_traffic();

        drain_replies();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
